/* sv/qte_pkg.sv */
`timescale 1ns / 1ps

package qte_pkg;

  localparam int CMP_W = 15;
  localparam int PRD_W = 30;
  localparam int CW = 36;
  localparam int AW = 35;
  localparam int DW = 31;
  localparam int VW = 62;
  localparam int RW = 34;
  localparam int SQ_STEPS = VW / 2;

  localparam logic signed [AW-1:0] HALF_TURN = AW'(64'sd2147483648);
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'sd1073741824);

  localparam logic [30:0] COEF_DEG = 31'd45;
  localparam logic [30:0] COEF_RAD = 31'd1686629713;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [CW-1:0] yaw_y;
    logic signed [CW-1:0] yaw_x;
    logic signed [CW-1:0] roll_y;
    logic signed [CW-1:0] roll_x;
    logic signed [CW-1:0] pitch_y;
  } side_t;

endpackage

/* sv/qte_if.sv */
`timescale 1ns / 1ps

interface qte_quat_if #(parameter int QW = 15) ();
  logic valid;
  logic ready;
  logic signed [QW-1:0] quat_real;
  logic signed [QW-1:0] quat_i;
  logic signed [QW-1:0] quat_j;
  logic signed [QW-1:0] quat_k;
  modport source(output valid, quat_real, quat_i, quat_j, quat_k, input ready);
  modport sink(input valid, quat_real, quat_i, quat_j, quat_k, output ready);
endinterface

interface qte_angle_if #(parameter int AWD = 16) ();
  logic valid;
  logic ready;
  logic signed [AWD-1:0] yaw_angle;
  logic signed [AWD-1:0] pitch_angle;
  logic signed [AWD-1:0] roll_angle;
  modport source(output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink(input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface qte_cfg_if ();
  logic valid;
  logic ready;
  logic output_in_degrees;
  modport source(output valid, output_in_degrees, input ready);
  modport sink(input valid, output_in_degrees, output ready);
endinterface

/* sv/qte_front.sv */
`timescale 1ns / 1ps

module qte_front import qte_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [QUAT_FRAC_BITS:0] q_r_in,
  input  logic signed [QUAT_FRAC_BITS:0] q_i_in,
  input  logic signed [QUAT_FRAC_BITS:0] q_j_in,
  input  logic signed [QUAT_FRAC_BITS:0] q_k_in,
  output logic                        out_valid,
  output logic [VW-1:0]               rad_out,
  output side_t                       side_out
);

  logic signed [CMP_W-1:0] cr, ci, cj, ck;

  if (QUAT_FRAC_BITS > 14) begin : g_shr
    always_comb begin
      cr = CMP_W'(q_r_in >>> (QUAT_FRAC_BITS - 14));
      ci = CMP_W'(q_i_in >>> (QUAT_FRAC_BITS - 14));
      cj = CMP_W'(q_j_in >>> (QUAT_FRAC_BITS - 14));
      ck = CMP_W'(q_k_in >>> (QUAT_FRAC_BITS - 14));
    end
  end else begin : g_ext
    always_comb begin
      cr = CMP_W'(q_r_in);
      ci = CMP_W'(q_i_in);
      cj = CMP_W'(q_j_in);
      ck = CMP_W'(q_k_in);
    end
  end

  // stage 1: products
  logic signed [PRD_W-1:0] rr_r, ii_r, jj_r, kk_r, ij_r, kr_r, jk_r, ir_r, jr_r, ik_r;
  logic v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_r <= cr * cr;
      ii_r <= ci * ci;
      jj_r <= cj * cj;
      kk_r <= ck * ck;
      ij_r <= ci * cj;
      kr_r <= ck * cr;
      jk_r <= cj * ck;
      ir_r <= ci * cr;
      jr_r <= cj * cr;
      ik_r <= ci * ck;
    end
  end

  // stage 2: sums
  side_t s2_r;
  logic signed [CW-1:0] n2s_r, d2s_r;
  logic v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r.yaw_y  <= (CW'(ij_r) + CW'(kr_r)) <<< 1;
      s2_r.yaw_x  <= CW'(ii_r) - CW'(jj_r) - CW'(kk_r) + CW'(rr_r);
      s2_r.roll_y <= (CW'(jk_r) + CW'(ir_r)) <<< 1;
      s2_r.roll_x <= CW'(kk_r) + CW'(rr_r) - CW'(ii_r) - CW'(jj_r);
      s2_r.pitch_y <= '0;
      n2s_r <= (CW'(jr_r) - CW'(ik_r)) <<< 1;
      d2s_r <= CW'(ii_r) + CW'(jj_r) + CW'(kk_r) + CW'(rr_r);
    end
  end

  // stage 3: clamp to [-d, d]
  side_t s3_r;
  logic [DW-1:0] d3_r, a3_r;
  logic v3_r;
  logic signed [CW-1:0] nc, na;

  always_comb begin
    if (n2s_r > d2s_r) begin
      nc = d2s_r;
    end else if (n2s_r < -d2s_r) begin
      nc = -d2s_r;
    end else begin
      nc = n2s_r;
    end
    na = nc[CW-1] ? -nc : nc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= '{yaw_y: s2_r.yaw_y, yaw_x: s2_r.yaw_x, roll_y: s2_r.roll_y,
                roll_x: s2_r.roll_x, pitch_y: nc};
      d3_r <= d2s_r[DW-1:0];
      a3_r <= na[DW-1:0];
    end
  end

  // stage 4: squares
  side_t s4_r;
  logic [VW-1:0] dd4_r, nn4_r;
  logic v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r  <= s3_r;
      dd4_r <= VW'(d3_r) * VW'(d3_r);
      nn4_r <= VW'(a3_r) * VW'(a3_r);
    end
  end

  // stage 5: radicand
  side_t s5_r;
  logic [VW-1:0] rad5_r;
  logic v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r   <= s4_r;
      rad5_r <= dd4_r - nn4_r;
    end
  end

  assign out_valid = v5_r;
  assign rad_out   = rad5_r;
  assign side_out  = s5_r;

endmodule

/* sv/qte_isqrt.sv */
`timescale 1ns / 1ps

module qte_isqrt import qte_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] rad_in,
  input  side_t         side_in,
  output logic          out_valid,
  output logic [DW-1:0] root_out,
  output side_t         side_out
);

  logic [RW-1:0] rem_r [SQ_STEPS];
  logic [DW-1:0] q_r [SQ_STEPS];
  logic [VW-1:0] v_r [SQ_STEPS];
  side_t         sd_r [SQ_STEPS];
  logic          vld_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
    logic [RW-1:0] rem_i, rem2, trial;
    logic [DW-1:0] q_i;
    logic [VW-1:0] v_i;
    side_t         sd_i;
    logic          vld_i;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign q_i   = '0;
      assign v_i   = rad_in;
      assign sd_i  = side_in;
      assign vld_i = in_valid;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign q_i   = q_r[k-1];
      assign v_i   = v_r[k-1];
      assign sd_i  = sd_r[k-1];
      assign vld_i = vld_r[k-1];
    end

    assign rem2  = {rem_i[RW-3:0], v_i[VW-1 -: 2]};
    assign trial = RW'({q_i, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]  <= {v_i[VW-3:0], 2'b00};
        sd_r[k] <= sd_i;
        if (rem2 >= trial) begin
          rem_r[k] <= rem2 - trial;
          q_r[k]   <= {q_i[DW-2:0], 1'b1};
        end else begin
          rem_r[k] <= rem2;
          q_r[k]   <= {q_i[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[SQ_STEPS-1];
  assign root_out  = q_r[SQ_STEPS-1];
  assign side_out  = sd_r[SQ_STEPS-1];

endmodule

/* sv/qte_cordic.sv */
`timescale 1ns / 1ps

module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] x_in,
  output logic                 out_valid,
  output logic signed [AW-1:0] ang_out
);

  logic signed [CW-1:0] x_r [STEPS+1];
  logic signed [CW-1:0] y_r [STEPS+1];
  logic signed [AW-1:0] a_r [STEPS+1];
  logic                 sp_r [STEPS+1];
  logic                 vld_r [STEPS+1];

  // quadrant fold and the axis cases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x_in;
      y_r[0] <= y_in;
      sp_r[0] <= 1'b0;
      a_r[0] <= '0;
      if (y_in == '0) begin
        sp_r[0] <= 1'b1;
        a_r[0]  <= x_in[CW-1] ? HALF_TURN : '0;
      end else if (x_in == '0) begin
        sp_r[0] <= 1'b1;
        a_r[0]  <= y_in[CW-1] ? -QUARTER_TURN : QUARTER_TURN;
      end else if (x_in[CW-1]) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        a_r[0] <= y_in[CW-1] ? -HALF_TURN : HALF_TURN;
      end
    end
  end

  for (genvar i = 1; i <= STEPS; i++) begin : g_it
    logic signed [CW-1:0] dx, dy;
    logic signed [AW-1:0] da;

    assign dx = y_r[i-1] >>> (i - 1);
    assign dy = x_r[i-1] >>> (i - 1);
    assign da = $signed(AW'(ATAN_TURNS[i-1]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sp_r[i] <= sp_r[i-1];
        if (sp_r[i-1]) begin
          x_r[i] <= x_r[i-1];
          y_r[i] <= y_r[i-1];
          a_r[i] <= a_r[i-1];
        end else if (!y_r[i-1][CW-1]) begin
          x_r[i] <= x_r[i-1] + dx;
          y_r[i] <= y_r[i-1] - dy;
          a_r[i] <= a_r[i-1] + da;
        end else begin
          x_r[i] <= x_r[i-1] - dx;
          y_r[i] <= y_r[i-1] + dy;
          a_r[i] <= a_r[i-1] - da;
        end
      end
    end
  end

  assign out_valid = vld_r[STEPS];
  assign ang_out   = a_r[STEPS];

endmodule

/* sv/qte_scale.sv */
`timescale 1ns / 1ps

module qte_scale import qte_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          deg,
  input  logic                          in_valid,
  input  logic signed [AW-1:0]          ang_in,
  output logic                          out_valid,
  output logic signed [ANGLE_WIDTH-1:0] angle_out
);

  localparam int HW = AW - 16 + 32;
  localparam int PW = 70;
  localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

  logic [30:0] coef;
  assign coef = deg ? COEF_DEG : COEF_RAD;

  // partial products
  logic signed [HW-1:0] hi_r;
  logic [46:0]          lo_r;
  logic                 v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r <= $signed(ang_in[AW-1:16]) * $signed({1'b0, coef});
      lo_r <= 47'(ang_in[15:0]) * 47'(coef);
    end
  end

  // sum, round, shift
  logic signed [PW-1:0] sum, sh_r;
  logic                 v2_r;

  assign sum = (PW'(hi_r) <<< 16) + $signed(PW'(lo_r))
             + (deg ? (PW'(1) <<< 21) : (PW'(1) <<< 46));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r <= deg ? (sum >>> 22) : (sum >>> 47);
    end
  end

  // saturate into the output register
  logic v3_r;
  logic signed [ANGLE_WIDTH-1:0] ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sh_r > SAT_HI) begin
        ang_r <= ANGLE_WIDTH'(SAT_HI);
      end else if (sh_r < SAT_LO) begin
        ang_r <= ANGLE_WIDTH'(SAT_LO);
      end else begin
        ang_r <= ANGLE_WIDTH'(sh_r);
      end
    end
  end

  assign out_valid = v3_r;
  assign angle_out = ang_r;

endmodule

/* sv/quaternion_to_euler_angles_unit.sv */
`timescale 1ns / 1ps
// Quaternion to ZYX Euler angles (yaw, pitch, roll). Fully pipelined: one quaternion per
// cycle while the output is not stalled, through product, sum, clamp, square and radicand
// stages, a bit-per-stage square root for the pitch arcsine, one fold stage plus
// CORDIC_STEPS vectoring CORDIC stages (three in parallel) and unit-scaling stages. The
// whole pipe halts while a result sits unaccepted at the output. output_in_degrees
// selects degrees*128 (reset) or radians*8192; write it only with the pipe empty.

module quaternion_to_euler_angles_unit import qte_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int ANGLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  qte_quat_if.sink     in_ch,
  qte_angle_if.source  out_ch,
  qte_cfg_if.sink      cfg_ch
);

  logic deg_r;
  logic en;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      deg_r <= cfg_ch.output_in_degrees;
    end
  end

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic          f_valid;
  logic [VW-1:0] f_rad;
  side_t         f_side;

  qte_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_ch.valid),
    .q_r_in(in_ch.quat_real), .q_i_in(in_ch.quat_i),
    .q_j_in(in_ch.quat_j), .q_k_in(in_ch.quat_k),
    .out_valid(f_valid), .rad_out(f_rad), .side_out(f_side)
  );

  logic          s_valid;
  logic [DW-1:0] s_root;
  side_t         s_side;

  qte_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(f_valid), .rad_in(f_rad), .side_in(f_side),
    .out_valid(s_valid), .root_out(s_root), .side_out(s_side)
  );

  logic signed [CW-1:0] pitch_x;
  assign pitch_x = $signed(CW'(s_root));

  logic yc_v, pc_v, rc_v;
  logic signed [AW-1:0] yaw_a, pitch_a, roll_a;

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_valid),
    .y_in(s_side.yaw_y), .x_in(s_side.yaw_x), .out_valid(yc_v), .ang_out(yaw_a)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_valid),
    .y_in(s_side.pitch_y), .x_in(pitch_x), .out_valid(pc_v), .ang_out(pitch_a)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_valid),
    .y_in(s_side.roll_y), .x_in(s_side.roll_x), .out_valid(rc_v), .ang_out(roll_a)
  );

  logic c_valid;
  assign c_valid = yc_v && pc_v && rc_v;

  logic yo_v, po_v, ro_v;

  qte_scale #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_scale_yaw (
    .clk(clk), .rst_n(rst_n), .en(en), .deg(deg_r), .in_valid(c_valid),
    .ang_in(yaw_a), .out_valid(yo_v), .angle_out(out_ch.yaw_angle)
  );

  qte_scale #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_scale_pitch (
    .clk(clk), .rst_n(rst_n), .en(en), .deg(deg_r), .in_valid(c_valid),
    .ang_in(pitch_a), .out_valid(po_v), .angle_out(out_ch.pitch_angle)
  );

  qte_scale #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_scale_roll (
    .clk(clk), .rst_n(rst_n), .en(en), .deg(deg_r), .in_valid(c_valid),
    .ang_in(roll_a), .out_valid(ro_v), .angle_out(out_ch.roll_angle)
  );

  assign out_ch.valid = yo_v && po_v && ro_v;

endmodule

/* sv/qte_checker.sv */
`timescale 1ns / 1ps

module qte_checker #(
  parameter int ANGLE_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   cfg_ready,
  input logic [ANGLE_WIDTH-1:0] out_yaw,
  input logic [ANGLE_WIDTH-1:0] out_pitch,
  input logic [ANGLE_WIDTH-1:0] out_roll
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_yaw) && $stable(out_pitch) && $stable(out_roll))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

  a_stall_in: assert property (@(posedge clk)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipe halted");

  a_free_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready && cfg_ready)
    else $error("input refused with empty output");

endmodule

bind quaternion_to_euler_angles_unit qte_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_qte_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .cfg_ready(cfg_ch.ready),
  .out_yaw(out_ch.yaw_angle),
  .out_pitch(out_ch.pitch_angle),
  .out_roll(out_ch.roll_angle)
);
